>>> rtl/core/assert_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked property, checked during reset as well.
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> rtl/core/yccf_pkg.sv
// Types, constants and config helpers for the YUYV crop/flip to RGB converter.
package yccf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int COL_W     = $clog2(MAX_WIDTH / 2);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int POS_W     = 11;
  localparam int WORD_W    = 32;
  localparam int CH_W      = 8;
  localparam int SUM_W     = 20;

  // BT.601 integer coefficients
  localparam int K_Y    = 298;
  localparam int K_RV   = 409;
  localparam int K_GU   = 100;
  localparam int K_GV   = 208;
  localparam int K_BU   = 516;
  localparam int K_RND  = 128;
  localparam int K_COFF = 128;
  localparam int K_YOFF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH   = 2'd0,
    REG_IN_HEIGHT  = 2'd1,
    REG_OUT_WIDTH  = 2'd2,
    REG_OUT_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] in_width;
    logic [CFG_W-1:0] in_height;
    logic [CFG_W-1:0] out_width;
    logic [CFG_W-1:0] out_height;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    in_width:   12'd640,
    in_height:  12'd480,
    out_width:  12'd640,
    out_height: 12'd480
  };

  typedef struct packed {
    cfg_reg_e         idx;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [CFG_W-1:0] wpr;
    logic [CFG_W-1:0] ih;
    logic [CFG_W-1:0] oh;
    logic [CFG_W-1:0] ow;
    logic [CFG_W-1:0] row_off;
    logic [CFG_W-1:0] col_off;
    logic [CFG_W-1:0] crop_words;
  } cfg_derived_t;

  typedef struct packed {
    logic             keep;
    logic             done;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pos_info_t;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // Clamp the raw sizes and work out the crop window.
  function automatic cfg_derived_t derive(cfg_regs_t r);
    logic [CFG_W-1:0] iw;
    logic [CFG_W-1:0] ih;
    logic [CFG_W-1:0] ow;
    logic [CFG_W-1:0] oh;
    cfg_derived_t     d;
    iw = r.in_width;
    if (iw < CFG_W'(2)) iw = CFG_W'(2);
    else if (int'(iw) > MAX_WIDTH) iw = CFG_W'(MAX_WIDTH);
    iw[0] = 1'b0;
    ih = r.in_height;
    if (ih < CFG_W'(1)) ih = CFG_W'(1);
    else if (int'(ih) > MAX_HEIGHT) ih = CFG_W'(MAX_HEIGHT);
    ow = r.out_width;
    if (ow < CFG_W'(2)) ow = CFG_W'(2);
    if (ow > iw) ow = iw;
    ow[0] = 1'b0;
    oh = r.out_height;
    if (oh < CFG_W'(1)) oh = CFG_W'(1);
    if (oh > ih) oh = ih;
    d.wpr        = iw >> 1;
    d.ih         = ih;
    d.oh         = oh;
    d.ow         = ow;
    d.row_off    = (ih - oh) >> 1;
    d.col_off    = (iw - ow) >> 2;
    d.crop_words = ow >> 1;
    return d;
  endfunction

endpackage

>>> rtl/core/yccf_if.sv
// Channel interfaces: YUYV input, RGB result output, config write.
interface yccf_in_if;
  logic                           valid;
  logic                           ready;
  logic [yccf_pkg::WORD_W-1:0]    yuyv_word;
  logic                           frame_start;

  modport source (output valid, output yuyv_word, output frame_start, input ready);
  modport sink   (input valid, input yuyv_word, input frame_start, output ready);
endinterface

interface yccf_out_if;
  logic                           valid;
  logic                           ready;
  logic [yccf_pkg::CH_W-1:0]      red_a;
  logic [yccf_pkg::CH_W-1:0]      green_a;
  logic [yccf_pkg::CH_W-1:0]      blue_a;
  logic [yccf_pkg::CH_W-1:0]      red_b;
  logic [yccf_pkg::CH_W-1:0]      green_b;
  logic [yccf_pkg::CH_W-1:0]      blue_b;
  logic [yccf_pkg::POS_W-1:0]     out_row;
  logic [yccf_pkg::POS_W-1:0]     out_col;
  logic                           frame_done;

  modport source (output valid, output red_a, output green_a, output blue_a,
                  output red_b, output green_b, output blue_b, output out_row,
                  output out_col, output frame_done, input ready);
  modport sink   (input valid, input red_a, input green_a, input blue_a,
                  input red_b, input green_b, input blue_b, input out_row,
                  input out_col, input frame_done, output ready);
endinterface

interface yccf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [yccf_pkg::CFG_IDX_W-1:0] index;
  logic [yccf_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/yccf_pos.sv
// Config registers, raster counters and crop window / mirrored position.
module yccf_pos (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr,
  input  yccf_pkg::cfg_wr_t      cfg_req,
  input  logic                   accept,
  input  logic                   frame_start,
  output yccf_pkg::pos_info_t    info
);

  yccf_pkg::cfg_regs_t               regs;
  yccf_pkg::cfg_regs_t               regs_next;
  yccf_pkg::cfg_derived_t            dv;
  logic [yccf_pkg::COL_W-1:0]        col;
  logic [yccf_pkg::ROW_W-1:0]        row;
  logic [yccf_pkg::COL_W-1:0]        cur_col;
  logic [yccf_pkg::ROW_W-1:0]        cur_row;
  logic [yccf_pkg::CFG_W-1:0]        col_w;
  logic [yccf_pkg::CFG_W-1:0]        row_w;
  logic [yccf_pkg::CFG_W-1:0]        crow;
  logic [yccf_pkg::CFG_W-1:0]        cword;
  logic [yccf_pkg::CFG_W-1:0]        mrow;
  logic [yccf_pkg::CFG_W-1:0]        mcol;
  logic [yccf_pkg::CFG_W-1:0]        col_inc;
  logic [yccf_pkg::CFG_W-1:0]        row_inc;
  logic                              in_rows;
  logic                              in_cols;
  logic                              wrap_col;
  logic                              wrap_row;

  always_comb begin
    regs_next = regs;
    if (cfg_wr) begin
      unique case (cfg_req.idx)
        yccf_pkg::REG_IN_WIDTH:   regs_next.in_width   = cfg_req.data;
        yccf_pkg::REG_IN_HEIGHT:  regs_next.in_height  = cfg_req.data;
        yccf_pkg::REG_OUT_WIDTH:  regs_next.out_width  = cfg_req.data;
        yccf_pkg::REG_OUT_HEIGHT: regs_next.out_height = cfg_req.data;
        default:                  regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= yccf_pkg::CFG_RESET;
      dv   <= yccf_pkg::derive(yccf_pkg::CFG_RESET);
    end else begin
      regs <= regs_next;
      dv   <= yccf_pkg::derive(regs_next);
    end
  end

  assign cur_col = frame_start ? '0 : col;
  assign cur_row = frame_start ? '0 : row;
  assign col_w   = yccf_pkg::CFG_W'(cur_col);
  assign row_w   = yccf_pkg::CFG_W'(cur_row);
  assign crow    = row_w - dv.row_off;
  assign cword   = col_w - dv.col_off;
  assign in_rows = (row_w >= dv.row_off) && (crow < dv.oh);
  assign in_cols = (col_w >= dv.col_off) && (cword < dv.crop_words);
  // mirrored in both directions
  assign mrow    = dv.oh - yccf_pkg::CFG_W'(1) - crow;
  assign mcol    = dv.ow - yccf_pkg::CFG_W'(1) - {cword[yccf_pkg::CFG_W-2:0], 1'b0};

  assign info.keep = in_rows && in_cols;
  assign info.done = (crow == dv.oh - yccf_pkg::CFG_W'(1)) &&
                     (cword == dv.crop_words - yccf_pkg::CFG_W'(1));
  assign info.row  = mrow[yccf_pkg::POS_W-1:0];
  assign info.col  = mcol[yccf_pkg::POS_W-1:0];

  assign col_inc  = col_w + yccf_pkg::CFG_W'(1);
  assign row_inc  = row_w + yccf_pkg::CFG_W'(1);
  assign wrap_col = col_inc >= dv.wpr;
  assign wrap_row = row_inc >= dv.ih;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (wrap_col) begin
        col <= '0;
        row <= wrap_row ? '0 : row_inc[yccf_pkg::ROW_W-1:0];
      end else begin
        col <= col_inc[yccf_pkg::COL_W-1:0];
        row <= cur_row;
      end
    end
  end

endmodule

>>> rtl/core/yccf_lane.sv
// One luma lane: adds the shared chroma terms to the scaled luma and clips.
module yccf_lane (
  input  logic [yccf_pkg::CH_W-1:0] y,
  input  yccf_pkg::sum_t            rt,
  input  yccf_pkg::sum_t            gt,
  input  yccf_pkg::sum_t            bt,
  output yccf_pkg::rgb_t            pix
);

  function automatic logic [yccf_pkg::CH_W-1:0] clip(yccf_pkg::sum_t s);
    logic [yccf_pkg::CH_W-1:0] r;
    if (s < 0) r = '0;
    else if (|s[yccf_pkg::SUM_W-1:16]) r = '1;
    else r = s[15:8];
    return r;
  endfunction

  yccf_pkg::sum_t ys;
  yccf_pkg::sum_t c;

  assign ys = $signed({{(yccf_pkg::SUM_W - yccf_pkg::CH_W){1'b0}}, y});
  assign c  = yccf_pkg::sum_t'(yccf_pkg::K_Y * (ys - yccf_pkg::K_YOFF));

  assign pix.red   = clip(c + rt);
  assign pix.green = clip(c + gt);
  assign pix.blue  = clip(c + bt);

endmodule

>>> rtl/core/yuyv_crop_flip_to_rgb.sv
// Top level: YUYV 4:2:2 crop, mirror and BT.601 conversion to two RGB pixels per word.
//
//  channel  | dir | payload                                         | handshake
//  in_ch    | in  | yuyv_word, frame_start                          | valid/ready
//  out_ch   | out | red/green/blue _a and _b, out_row, out_col, done | valid/ready
//  cfg_ch   | in  | index, data (four 12-bit size registers)        | valid/ready
//
// One word per clock while the output is not stalled; each accepted word is registered in stage 1, then in stage 2.
// Stage 1 holds crop position and chroma products, stage 2 the two lane outputs.
// Words outside the crop window pass stage 1 and are dropped, emitting nothing.
// Output stall backs up through both stages; ready follows the free stage.
// Reset (synchronous) restores the 640x480 sizes and clears the raster counters.
`include "assert_macros.svh"

module yuyv_crop_flip_to_rgb (
  input  logic clk,
  input  logic rst,
  yccf_in_if.sink    in_ch,
  yccf_out_if.source out_ch,
  yccf_cfg_if.sink   cfg_ch
);

  logic                          in_acc;
  logic                          s1_valid;
  logic                          s1_ready;
  logic                          s2_ready;
  logic                          out_valid;
  yccf_pkg::cfg_wr_t             cfg_req;
  yccf_pkg::pos_info_t           pos_info;
  yccf_pkg::pos_info_t           s1_info;
  logic [yccf_pkg::CH_W-1:0]     s1_ya;
  logic [yccf_pkg::CH_W-1:0]     s1_yb;
  yccf_pkg::sum_t                s1_rt;
  yccf_pkg::sum_t                s1_gt;
  yccf_pkg::sum_t                s1_bt;
  yccf_pkg::sum_t                du;
  yccf_pkg::sum_t                dv;
  yccf_pkg::sum_t                rt_c;
  yccf_pkg::sum_t                gt_c;
  yccf_pkg::sum_t                bt_c;
  yccf_pkg::rgb_t                pix_a;
  yccf_pkg::rgb_t                pix_b;
  yccf_pkg::rgb_t                out_a;
  yccf_pkg::rgb_t                out_b;
  yccf_pkg::pos_info_t           out_info;

  assign cfg_ch.ready = 1'b1;
  assign cfg_req.idx  = yccf_pkg::cfg_reg_e'(cfg_ch.index);
  assign cfg_req.data = cfg_ch.data;

  assign s2_ready    = !out_valid || out_ch.ready;
  assign s1_ready    = !s1_valid || s2_ready;
  assign in_ch.ready = s1_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  yccf_pos u_pos (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_ch.valid),
    .cfg_req     (cfg_req),
    .accept      (in_acc),
    .frame_start (in_ch.frame_start),
    .info        (pos_info)
  );

  // shared chroma terms: U at 31:24, V at 15:8
  assign du   = $signed({{(yccf_pkg::SUM_W - yccf_pkg::CH_W){1'b0}}, in_ch.yuyv_word[31:24]})
                - yccf_pkg::sum_t'(yccf_pkg::K_COFF);
  assign dv   = $signed({{(yccf_pkg::SUM_W - yccf_pkg::CH_W){1'b0}}, in_ch.yuyv_word[15:8]})
                - yccf_pkg::sum_t'(yccf_pkg::K_COFF);
  assign rt_c = yccf_pkg::sum_t'(yccf_pkg::K_RV * dv + yccf_pkg::K_RND);
  assign gt_c = yccf_pkg::sum_t'(yccf_pkg::K_RND - yccf_pkg::K_GU * du - yccf_pkg::K_GV * dv);
  assign bt_c = yccf_pkg::sum_t'(yccf_pkg::K_BU * du + yccf_pkg::K_RND);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_acc;
      if (s2_ready) out_valid <= s1_valid && s1_info.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_info <= pos_info;
      s1_ya   <= in_ch.yuyv_word[7:0];
      s1_yb   <= in_ch.yuyv_word[23:16];
      s1_rt   <= rt_c;
      s1_gt   <= gt_c;
      s1_bt   <= bt_c;
    end
  end

  yccf_lane u_lane_a (
    .y   (s1_ya),
    .rt  (s1_rt),
    .gt  (s1_gt),
    .bt  (s1_bt),
    .pix (pix_a)
  );

  yccf_lane u_lane_b (
    .y   (s1_yb),
    .rt  (s1_rt),
    .gt  (s1_gt),
    .bt  (s1_bt),
    .pix (pix_b)
  );

  // merge lanes with position into the output register
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      out_a    <= pix_a;
      out_b    <= pix_b;
      out_info <= s1_info;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.red_a      = out_a.red;
  assign out_ch.green_a    = out_a.green;
  assign out_ch.blue_a     = out_a.blue;
  assign out_ch.red_b      = out_b.red;
  assign out_ch.green_b    = out_b.green;
  assign out_ch.blue_b     = out_b.blue;
  assign out_ch.out_row    = out_info.row;
  assign out_ch.out_col    = out_info.col;
  assign out_ch.frame_done = out_info.done;

  `ASSERT_CLK(a_full_stall, clk, rst, (out_valid && !out_ch.ready && s1_valid) |-> !in_ch.ready, "input taken while both stages are held")
  `ASSERT_CLK(a_done_corner, clk, rst, (out_valid && out_info.done) |-> (out_info.row == '0 && out_info.col == yccf_pkg::POS_W'(1)), "last transaction of crop not at mirrored origin")
  `ASSERT_CLK_NR(a_reset_idle, clk, rst |=> !out_ch.valid, "output valid right after reset")

endmodule
